@@ hdl/dspid_pkg.sv @@
// ----------------------------------------------------------------------------
// dspid_pkg
// Types and opcode constants shared by the DSP instruction decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dspid_pkg;

  typedef enum logic [4:0] {
    K_CONST       = 5'd0,
    K_NOP         = 5'd1,
    K_GOTO_FAR    = 5'd2,
    K_GOTO_NEAR   = 5'd3,
    K_SUBENTRY    = 5'd4,
    K_RETURN      = 5'd5,
    K_PUSH_RA     = 5'd6,
    K_POP_RA      = 5'd7,
    K_PUSH_RD     = 5'd8,
    K_POP_RD      = 5'd9,
    K_LOAD_IMM    = 5'd10,
    K_ROM         = 5'd11,
    K_UNARY       = 5'd12,
    K_TABLE       = 5'd13,
    K_RA_ADDSUB   = 5'd14,
    K_RAM         = 5'd15,
    K_RD_MEM      = 5'd16,
    K_RA_MEM      = 5'd17,
    K_ALU         = 5'd18,
    K_PUSH_RP     = 5'd19,
    K_POP_RP      = 5'd20,
    K_RP_MEM      = 5'd21,
    K_SET_CLEAR   = 5'd22,
    K_UNKNOWN     = 5'd23
  } kind_e;

  typedef enum logic [2:0] {
    M_RD       = 3'd0,
    M_RA_RD    = 3'd1,
    M_PRE_INC  = 3'd2,
    M_PRE_DEC  = 3'd3,
    M_POST_INC = 3'd4,
    M_POST_DEC = 3'd5,
    M_RM       = 3'd6,
    M_RA_OFS   = 3'd7
  } mem_mode_e;

  // opcode words and masks
  localparam logic [31:0] NOP_WORD      = 32'h0000_A9F4;
  localparam logic [31:0] SUBENTRY_WORD = 32'h0000_3BFA;

  localparam logic [15:0] MSK_C100 = 16'hC100;
  localparam logic [15:0] MSK_C000 = 16'hC000;
  localparam logic [15:0] MSK_FFC0 = 16'hFFC0;
  localparam logic [15:0] MSK_F9FF = 16'hF9FF;
  localparam logic [15:0] MSK_F900 = 16'hF900;
  localparam logic [15:0] MSK_E100 = 16'hE100;
  localparam logic [15:0] MSK_F800 = 16'hF800;
  localparam logic [15:0] MSK_C0FF = 16'hC0FF;
  localparam logic [15:0] MSK_FD00 = 16'hFD00;

  localparam logic [15:0] PAT_FAR      = 16'h0000;
  localparam logic [15:0] PAT_NEAR     = 16'h4000;
  localparam logic [15:0] PAT_RETURN   = 16'h39C0;
  localparam logic [15:0] PAT_PUSH_RA  = 16'hF8FA;
  localparam logic [15:0] PAT_POP_RA   = 16'hF9F9;
  localparam logic [15:0] PAT_PUSH_RD  = 16'hA8FA;
  localparam logic [15:0] PAT_POP_RD   = 16'hA9F9;
  localparam logic [15:0] PAT_LOAD_IMM = 16'h3100;
  localparam logic [15:0] PAT_ROM      = 16'h2900;
  localparam logic [15:0] PAT_UNARY    = 16'h2100;
  localparam logic [15:0] PAT_TABLE    = 16'h0100;
  localparam logic [15:0] PAT_RA_ADD   = 16'hB800;
  localparam logic [15:0] PAT_RAM      = 16'hB000;
  localparam logic [15:0] PAT_RD_MEM   = 16'hA800;
  localparam logic [15:0] PAT_RA_MEM   = 16'hF800;
  localparam logic [15:0] PAT_ALU      = 16'h8000;
  localparam logic [15:0] PAT_PUSH_RP  = 16'hC0FA;
  localparam logic [15:0] PAT_POP_RP   = 16'hC0F9;
  localparam logic [15:0] PAT_RP_MEM   = 16'hC000;
  localparam logic [15:0] PAT_SET_CLR  = 16'h3D00;

  // memory operand sub-field
  localparam logic [7:0] MSK_MEM_FC = 8'hFC;
  localparam logic [7:0] MSK_MEM_3C = 8'h3C;
  localparam logic [7:0] MSK_MEM_38 = 8'h38;
  localparam logic [7:0] PAT_MEM_RD = 8'hF4;
  localparam logic [7:0] PAT_MEM_RA = 8'h3C;
  localparam logic [7:0] PAT_MEM_ID = 8'h38;
  localparam logic [7:0] PAT_MEM_RM = 8'h30;

  localparam logic [7:0] CONST_LO = 8'd5;

  typedef struct packed {
    mem_mode_e   mode;
    logic [1:0]  base;
    logic [5:0]  field;
  } mem_t;

  typedef struct packed {
    kind_e       kind;
    logic        direction;
    logic [4:0]  reg_num;
    logic [2:0]  alu_op;
    logic [4:0]  cond_flag;
    logic [23:0] value;
    logic        has_mem;
    mem_t        mem;
  } dec_t;

endpackage

@@ hdl/dspid_mem_dec.sv @@
// ----------------------------------------------------------------------------
// dspid_mem_dec
// Decodes the 8-bit memory operand into addressing mode, base and field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dspid_mem_dec
  import dspid_pkg::*;
(
  input  logic [7:0] opnd_i,
  output mem_t       mem_o
);

  logic [1:0] ra;

  assign ra = opnd_i[7:6];

  always_comb begin
    mem_o = '0;
    priority if ((opnd_i & MSK_MEM_FC) == PAT_MEM_RD) begin
      mem_o.mode  = M_RD;
      mem_o.field = {4'd0, opnd_i[1:0]};
    end else if ((opnd_i & MSK_MEM_3C) == PAT_MEM_RA) begin
      mem_o.mode  = M_RA_RD;
      mem_o.base  = ra;
      mem_o.field = {4'd0, opnd_i[1:0]};
    end else if ((opnd_i & MSK_MEM_3C) == PAT_MEM_ID) begin
      unique case (opnd_i[1:0])
        2'b11:   mem_o.mode = M_PRE_INC;
        2'b10:   mem_o.mode = M_PRE_DEC;
        2'b01:   mem_o.mode = M_POST_INC;
        default: mem_o.mode = M_POST_DEC;
      endcase
      mem_o.base = ra;
    end else if ((opnd_i & MSK_MEM_38) == PAT_MEM_RM) begin
      mem_o.mode  = M_RM;
      mem_o.field = {1'b0, opnd_i[2], ra, opnd_i[1:0]};
    end else begin
      mem_o.mode  = M_RA_OFS;
      mem_o.base  = ra;
      mem_o.field = opnd_i[5:0];
    end
  end

endmodule

@@ hdl/dspid_dec.sv @@
// ----------------------------------------------------------------------------
// dspid_dec
// Priority decode of one instruction word and its fetch address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dspid_dec
  import dspid_pkg::*;
(
  input  logic [23:0] fetch_address_i,
  input  logic [31:0] instr_word_i,
  output dec_t        dec_o
);

  logic [15:0] lo;
  logic [15:0] hi;
  logic [7:0]  n;
  logic [4:0]  flag;
  logic [1:0]  r2;
  logic        rw;
  logic [23:0] near_ofs;
  logic [23:0] near_tgt;
  logic        is_const;
  mem_t        mem;

  assign lo   = instr_word_i[15:0];
  assign hi   = instr_word_i[31:16];
  assign n    = instr_word_i[7:0];
  assign flag = instr_word_i[13:9];
  assign r2   = instr_word_i[10:9];
  assign rw   = instr_word_i[8];

  assign near_ofs = rw ? {16'd0, n} : (24'd0 - {16'd0, n});
  assign near_tgt = fetch_address_i + near_ofs + 24'd1;
  assign is_const = (fetch_address_i[23:8] == 16'd0) && (fetch_address_i[7:0] > CONST_LO);

  dspid_mem_dec u_mem_dec (
    .opnd_i (n),
    .mem_o  (mem)
  );

  always_comb begin
    dec_o      = '0;
    dec_o.kind = K_UNKNOWN;
    priority if (is_const) begin
      dec_o.kind  = K_CONST;
      dec_o.value = {8'd0, lo};
    end else if (instr_word_i == NOP_WORD) begin
      dec_o.kind = K_NOP;
    end else if ((lo & MSK_C100) == PAT_FAR) begin
      dec_o.kind      = K_GOTO_FAR;
      dec_o.cond_flag = flag;
      dec_o.value     = {n, hi};
    end else if ((lo & MSK_C000) == PAT_NEAR) begin
      dec_o.kind      = K_GOTO_NEAR;
      dec_o.cond_flag = flag;
      dec_o.direction = rw;
      dec_o.value     = near_tgt;
    end else if (instr_word_i == SUBENTRY_WORD) begin
      dec_o.kind = K_SUBENTRY;
    end else if ((lo & MSK_FFC0) == PAT_RETURN) begin
      dec_o.kind  = K_RETURN;
      dec_o.value = {18'd0, lo[5:0]};
    end else if ((lo & MSK_F9FF) == PAT_PUSH_RA) begin
      dec_o.kind    = K_PUSH_RA;
      dec_o.reg_num = {3'd0, r2};
    end else if ((lo & MSK_F9FF) == PAT_POP_RA) begin
      dec_o.kind    = K_POP_RA;
      dec_o.reg_num = {3'd0, r2};
    end else if ((lo & MSK_F9FF) == PAT_PUSH_RD) begin
      dec_o.kind    = K_PUSH_RD;
      dec_o.reg_num = {3'd0, r2};
    end else if ((lo & MSK_F9FF) == PAT_POP_RD) begin
      dec_o.kind    = K_POP_RD;
      dec_o.reg_num = {3'd0, r2};
    end else if ((lo & MSK_F900) == PAT_LOAD_IMM) begin
      dec_o.kind    = K_LOAD_IMM;
      dec_o.reg_num = {3'd0, r2};
      dec_o.value   = {n, hi};
    end else if ((lo & MSK_F900) == PAT_ROM) begin
      dec_o.kind    = K_ROM;
      dec_o.reg_num = {3'd0, r2};
      dec_o.value   = {16'd0, n};
    end else if ((lo & MSK_F900) == PAT_UNARY) begin
      dec_o.kind    = K_UNARY;
      dec_o.alu_op  = {1'b0, r2};
      dec_o.has_mem = 1'b1;
      dec_o.mem     = mem;
    end else if ((lo & MSK_E100) == PAT_TABLE) begin
      dec_o.kind    = K_TABLE;
      dec_o.reg_num = {1'b0, lo[12:9]};
      dec_o.has_mem = 1'b1;
      dec_o.mem     = mem;
    end else if ((lo & MSK_F800) == PAT_RA_ADD) begin
      dec_o.kind      = K_RA_ADDSUB;
      dec_o.direction = rw;
      dec_o.reg_num   = {3'd0, r2};
      dec_o.value     = {16'd0, n};
    end else if ((lo & MSK_F800) == PAT_RAM) begin
      dec_o.kind      = K_RAM;
      dec_o.direction = rw;
      dec_o.reg_num   = {3'd0, r2};
      dec_o.value     = {16'd0, n};
    end else if ((lo & MSK_F800) == PAT_RD_MEM) begin
      dec_o.kind      = K_RD_MEM;
      dec_o.direction = rw;
      dec_o.reg_num   = {3'd0, r2};
      dec_o.has_mem   = 1'b1;
      dec_o.mem       = mem;
    end else if ((lo & MSK_F800) == PAT_RA_MEM) begin
      dec_o.kind      = K_RA_MEM;
      dec_o.direction = rw;
      dec_o.reg_num   = {3'd0, r2};
      dec_o.has_mem   = 1'b1;
      dec_o.mem       = mem;
    end else if ((lo & MSK_C000) == PAT_ALU) begin
      dec_o.kind      = K_ALU;
      dec_o.direction = rw;
      dec_o.reg_num   = {3'd0, r2};
      dec_o.alu_op    = lo[13:11];
      dec_o.has_mem   = 1'b1;
      dec_o.mem       = mem;
    end else if ((lo & MSK_C0FF) == PAT_PUSH_RP) begin
      dec_o.kind    = K_PUSH_RP;
      dec_o.reg_num = flag;
    end else if ((lo & MSK_C0FF) == PAT_POP_RP) begin
      dec_o.kind    = K_POP_RP;
      dec_o.reg_num = flag;
    end else if ((lo & MSK_C000) == PAT_RP_MEM) begin
      dec_o.kind      = K_RP_MEM;
      dec_o.direction = rw;
      dec_o.reg_num   = flag;
      dec_o.has_mem   = 1'b1;
      dec_o.mem       = mem;
    end else if ((lo & MSK_FD00) == PAT_SET_CLR) begin
      dec_o.kind      = K_SET_CLEAR;
      dec_o.direction = lo[9];
      dec_o.value     = {16'd0, n};
    end else begin
      dec_o.kind = K_UNKNOWN;
    end
  end

endmodule

@@ hdl/dsp_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// dsp_instruction_decoder
// An accepted input is held in the input register, then decoded into the
// result register. Throughput: one item per cycle, held back only by a
// stalled result register. Reset clears both stage valid flags; payload
// registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsp_instruction_decoder
  import dspid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] fetch_address_i,
  input  logic [31:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  kind_o,
  output logic        direction_o,
  output logic [4:0]  reg_num_o,
  output logic [2:0]  alu_op_o,
  output logic [4:0]  cond_flag_o,
  output logic [23:0] value_o,
  output logic        has_mem_o,
  output logic [2:0]  mem_mode_o,
  output logic [1:0]  mem_base_o,
  output logic [5:0]  mem_field_o
);

  logic        in_vld_q;
  logic [23:0] addr_q;
  logic [31:0] word_q;
  logic        res_vld_q;
  dec_t        res_q;
  dec_t        res_d;
  logic        res_en;
  logic        in_en;

  assign res_en     = !res_vld_q || !out_stall_i;
  assign in_en      = !in_vld_q || res_en;
  assign in_stall_o = !in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      addr_q <= fetch_address_i;
      word_q <= instr_word_i;
    end
  end

  dspid_dec u_dec (
    .fetch_address_i (addr_q),
    .instr_word_i    (word_q),
    .dec_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_en) begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_en && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign kind_o      = res_q.kind;
  assign direction_o = res_q.direction;
  assign reg_num_o   = res_q.reg_num;
  assign alu_op_o    = res_q.alu_op;
  assign cond_flag_o = res_q.cond_flag;
  assign value_o     = res_q.value;
  assign has_mem_o   = res_q.has_mem;
  assign mem_mode_o  = res_q.mem.mode;
  assign mem_base_o  = res_q.mem.base;
  assign mem_field_o = res_q.mem.field;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DSP instruction decoder. A queue of fetch items
// (directed corner cases, then random words shaped toward each opcode class)
// feeds a valid/stall driver. Every accepted item is decoded by an independent
// predictor. A monitor checks each accepted result, field by field, against
// the oldest prediction, with random idles and stalls in the first two thirds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dspid_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 400;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic [23:0] addr;
    logic [31:0] word;
  } fetch_item_t;

  typedef struct packed {
    kind_e       kind;
    logic        dir;
    logic [4:0]  rnum;
    logic [2:0]  op;
    logic [4:0]  cond;
    logic [23:0] value;
    logic        has_mem;
    mem_mode_e   mode;
    logic [1:0]  base;
    logic [5:0]  field;
  } decoded_fields_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [23:0] fetch_address_i = '0;
  logic [31:0] instr_word_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [4:0]  kind_o;
  logic        direction_o;
  logic [4:0]  reg_num_o;
  logic [2:0]  alu_op_o;
  logic [4:0]  cond_flag_o;
  logic [23:0] value_o;
  logic        has_mem_o;
  logic [2:0]  mem_mode_o;
  logic [1:0]  mem_base_o;
  logic [5:0]  mem_field_o;

  fetch_item_t     fetch_q[$];
  decoded_fields_t decoded_q[$];

  int unsigned total_items  = 0;
  int unsigned sent_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  dsp_instruction_decoder i_dut (.*);

  always #6 clk_i = ~clk_i;

  // decode of the 8-bit memory operand
  function automatic decoded_fields_t decode_operand(decoded_fields_t d, logic [7:0] c);
    d.has_mem = 1'b1;
    if ((c & MSK_MEM_FC) == PAT_MEM_RD) begin
      d.mode  = M_RD;
      d.base  = 2'd0;
      d.field = {4'd0, c[1:0]};
    end else if ((c & MSK_MEM_3C) == PAT_MEM_RA) begin
      d.mode  = M_RA_RD;
      d.base  = c[7:6];
      d.field = {4'd0, c[1:0]};
    end else if ((c & MSK_MEM_3C) == PAT_MEM_ID) begin
      if (c[1]) begin
        d.mode = c[0] ? M_PRE_INC : M_PRE_DEC;
      end else begin
        d.mode = c[0] ? M_POST_INC : M_POST_DEC;
      end
      d.base  = c[7:6];
      d.field = '0;
    end else if ((c & MSK_MEM_38) == PAT_MEM_RM) begin
      d.mode  = M_RM;
      d.base  = 2'd0;
      d.field = {1'b0, c[2], c[7:6], c[1:0]};
    end else begin
      d.mode  = M_RA_OFS;
      d.base  = c[7:6];
      d.field = c[5:0];
    end
    return d;
  endfunction

  function automatic decoded_fields_t decode_instr(logic [23:0] ip, logic [31:0] w);
    decoded_fields_t d;
    logic [15:0] lo;
    logic [7:0]  n;
    logic        rw;
    d    = '0;
    lo   = w[15:0];
    n    = w[7:0];
    rw   = w[8];
    d.kind = K_UNKNOWN;
    if (ip < 24'd256 && ip > {16'd0, CONST_LO}) begin
      d.kind  = K_CONST;
      d.value = {8'd0, lo};
    end else if (w == NOP_WORD) begin
      d.kind = K_NOP;
    end else if ((lo & MSK_C100) == PAT_FAR) begin
      d.kind  = K_GOTO_FAR;
      d.cond  = w[13:9];
      d.value = {n, w[31:16]};
    end else if ((lo & MSK_C000) == PAT_NEAR) begin
      d.kind  = K_GOTO_NEAR;
      d.cond  = w[13:9];
      d.dir   = rw;
      d.value = rw ? ip + {16'd0, n} + 24'd1 : ip - {16'd0, n} + 24'd1;
    end else if (w == SUBENTRY_WORD) begin
      d.kind = K_SUBENTRY;
    end else if ((lo & MSK_FFC0) == PAT_RETURN) begin
      d.kind  = K_RETURN;
      d.value = {18'd0, w[5:0]};
    end else if ((lo & MSK_F9FF) == PAT_PUSH_RA) begin
      d.kind = K_PUSH_RA;
      d.rnum = {3'd0, w[10:9]};
    end else if ((lo & MSK_F9FF) == PAT_POP_RA) begin
      d.kind = K_POP_RA;
      d.rnum = {3'd0, w[10:9]};
    end else if ((lo & MSK_F9FF) == PAT_PUSH_RD) begin
      d.kind = K_PUSH_RD;
      d.rnum = {3'd0, w[10:9]};
    end else if ((lo & MSK_F9FF) == PAT_POP_RD) begin
      d.kind = K_POP_RD;
      d.rnum = {3'd0, w[10:9]};
    end else if ((lo & MSK_F900) == PAT_LOAD_IMM) begin
      d.kind  = K_LOAD_IMM;
      d.rnum  = {3'd0, w[10:9]};
      d.value = {n, w[31:16]};
    end else if ((lo & MSK_F900) == PAT_ROM) begin
      d.kind  = K_ROM;
      d.rnum  = {3'd0, w[10:9]};
      d.value = {16'd0, n};
    end else if ((lo & MSK_F900) == PAT_UNARY) begin
      d.kind = K_UNARY;
      d.op   = {1'b0, w[10:9]};
      d      = decode_operand(d, n);
    end else if ((lo & MSK_E100) == PAT_TABLE) begin
      d.kind = K_TABLE;
      d.rnum = {1'b0, w[12:9]};
      d      = decode_operand(d, n);
    end else if ((lo & MSK_F800) == PAT_RA_ADD) begin
      d.kind  = K_RA_ADDSUB;
      d.dir   = rw;
      d.rnum  = {3'd0, w[10:9]};
      d.value = {16'd0, n};
    end else if ((lo & MSK_F800) == PAT_RAM) begin
      d.kind  = K_RAM;
      d.dir   = rw;
      d.rnum  = {3'd0, w[10:9]};
      d.value = {16'd0, n};
    end else if ((lo & MSK_F800) == PAT_RD_MEM) begin
      d.kind = K_RD_MEM;
      d.dir  = rw;
      d.rnum = {3'd0, w[10:9]};
      d      = decode_operand(d, n);
    end else if ((lo & MSK_F800) == PAT_RA_MEM) begin
      d.kind = K_RA_MEM;
      d.dir  = rw;
      d.rnum = {3'd0, w[10:9]};
      d      = decode_operand(d, n);
    end else if ((lo & MSK_C000) == PAT_ALU) begin
      d.kind = K_ALU;
      d.dir  = rw;
      d.rnum = {3'd0, w[10:9]};
      d.op   = w[13:11];
      d      = decode_operand(d, n);
    end else if ((lo & MSK_C0FF) == PAT_PUSH_RP) begin
      d.kind = K_PUSH_RP;
      d.rnum = w[13:9];
    end else if ((lo & MSK_C0FF) == PAT_POP_RP) begin
      d.kind = K_POP_RP;
      d.rnum = w[13:9];
    end else if ((lo & MSK_C000) == PAT_RP_MEM) begin
      d.kind = K_RP_MEM;
      d.dir  = rw;
      d.rnum = w[13:9];
      d      = decode_operand(d, n);
    end else if ((lo & MSK_FD00) == PAT_SET_CLR) begin
      d.kind  = K_SET_CLEAR;
      d.dir   = w[9];
      d.value = {16'd0, n};
    end
    return d;
  endfunction

  task automatic add_fetch(input logic [23:0] addr, input logic [31:0] word);
    fetch_item_t item;
    item.addr = addr;
    item.word = word;
    fetch_q.push_back(item);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // sender idles and receiver stalls per phase of the run
  always_comb begin
    if (sent_count < total_items / 3) begin
      send_idle_pct  = 10;
      recv_stall_pct = 48;
    end else if (sent_count < 2 * total_items / 3) begin
      send_idle_pct  = 48;
      recv_stall_pct = 10;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    fetch_item_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (fetch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = fetch_q.pop_front();
        in_valid_i      <= 1'b1;
        fetch_address_i <= item.addr;
        instr_word_i    <= item.word;
        sent_count      <= sent_count + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    decoded_fields_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          note_mismatch("unexpected item, kind", '0, 32'(kind_o));
        end else begin
          want = decoded_q.pop_front();
          if (want.kind !== kind_o)
            note_mismatch("kind", 32'(want.kind), 32'(kind_o));
          if (want.dir !== direction_o)
            note_mismatch("direction", 32'(want.dir), 32'(direction_o));
          if (want.rnum !== reg_num_o)
            note_mismatch("reg_num", 32'(want.rnum), 32'(reg_num_o));
          if (want.op !== alu_op_o)
            note_mismatch("alu_op", 32'(want.op), 32'(alu_op_o));
          if (want.cond !== cond_flag_o)
            note_mismatch("cond_flag", 32'(want.cond), 32'(cond_flag_o));
          if (want.value !== value_o)
            note_mismatch("value", 32'(want.value), 32'(value_o));
          if (want.has_mem !== has_mem_o)
            note_mismatch("has_mem", 32'(want.has_mem), 32'(has_mem_o));
          if (want.mode !== mem_mode_o)
            note_mismatch("mem_mode", 32'(want.mode), 32'(mem_mode_o));
          if (want.base !== mem_base_o)
            note_mismatch("mem_base", 32'(want.base), 32'(mem_base_o));
          if (want.field !== mem_field_o)
            note_mismatch("mem_field", 32'(want.field), 32'(mem_field_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        decoded_q.push_back(decode_instr(fetch_address_i, instr_word_i));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [23:0] addr;
    logic [31:0] word;
    logic [15:0] msk;
    logic [15:0] pat;
    logic [7:0]  c;
    logic        has_operand;

    // corner cases of the address map and of each opcode class
    add_fetch(24'd6, 32'hFFFF_FFFF);
    add_fetch(24'd255, $urandom());
    add_fetch(24'd5, NOP_WORD);
    add_fetch(24'd256, NOP_WORD | 32'h0001_0000);
    add_fetch(24'd0, 32'hFFFF_3EFF);
    add_fetch(24'hFF_FFFF, 32'h0000_0000);
    add_fetch(24'd0, 32'h0000_40FF);
    add_fetch(24'hFF_FFFF, 32'h0000_7FFF);
    add_fetch(24'd1000, SUBENTRY_WORD);
    add_fetch(24'd1000, SUBENTRY_WORD | 32'h8000_0000);
    add_fetch(24'd1000, 32'h0000_39C0);
    add_fetch(24'd1000, 32'h0000_39FF);
    add_fetch(24'd300, 32'h0000_FEFA);
    add_fetch(24'd300, 32'h0000_F9F9);
    add_fetch(24'd300, 32'h0000_AEFA);
    add_fetch(24'd300, 32'hFFFF_37FF);
    add_fetch(24'd300, 32'h0000_29AB);
    add_fetch(24'd300, 32'h0000_27F4);
    add_fetch(24'd300, 32'h0000_1F3F);
    add_fetch(24'd300, 32'h0000_BFFF);
    add_fetch(24'd300, 32'h0000_B100);
    add_fetch(24'd300, 32'h0000_AD3B);
    add_fetch(24'd300, 32'h0000_F93A);
    add_fetch(24'd300, 32'h0000_A6B7);
    add_fetch(24'd300, 32'h0000_DEFA);
    add_fetch(24'd300, 32'h0000_C0F9);
    add_fetch(24'd300, 32'h0000_C107);
    add_fetch(24'd300, 32'h0000_3FFF);
    add_fetch(24'd300, 32'h0000_3900);

    // random words, mostly shaped into one opcode class
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(9))
        0:       addr = 24'($urandom_range(255));
        1:       addr = 24'hFF_FFFF - 24'($urandom_range(255));
        default: addr = 24'($urandom());
      endcase
      word        = $urandom();
      has_operand = 1'b0;
      msk         = '0;
      pat         = '0;
      case ($urandom_range(23))
        0:  begin msk = MSK_C100; pat = PAT_FAR;      end
        1:  begin msk = MSK_C000; pat = PAT_NEAR;     end
        2:  word = NOP_WORD;
        3:  word = SUBENTRY_WORD;
        4:  begin msk = MSK_FFC0; pat = PAT_RETURN;   end
        5:  begin msk = MSK_F9FF; pat = PAT_PUSH_RA;  end
        6:  begin msk = MSK_F9FF; pat = PAT_POP_RA;   end
        7:  begin msk = MSK_F9FF; pat = PAT_PUSH_RD;  end
        8:  begin msk = MSK_F9FF; pat = PAT_POP_RD;   end
        9:  begin msk = MSK_F900; pat = PAT_LOAD_IMM; end
        10: begin msk = MSK_F900; pat = PAT_ROM;      end
        11: begin msk = MSK_F900; pat = PAT_UNARY;  has_operand = 1'b1; end
        12: begin msk = MSK_E100; pat = PAT_TABLE;  has_operand = 1'b1; end
        13: begin msk = MSK_F800; pat = PAT_RA_ADD;   end
        14: begin msk = MSK_F800; pat = PAT_RAM;      end
        15: begin msk = MSK_F800; pat = PAT_RD_MEM; has_operand = 1'b1; end
        16: begin msk = MSK_F800; pat = PAT_RA_MEM; has_operand = 1'b1; end
        17: begin msk = MSK_C000; pat = PAT_ALU;    has_operand = 1'b1; end
        18: begin msk = MSK_C0FF; pat = PAT_PUSH_RP;  end
        19: begin msk = MSK_C0FF; pat = PAT_POP_RP;   end
        20: begin msk = MSK_C000; pat = PAT_RP_MEM; has_operand = 1'b1; end
        21: begin msk = MSK_FD00; pat = PAT_SET_CLR;  end
        // unrecognized area sits among return and subentry
        22: begin msk = MSK_FD00; pat = PAT_RETURN & MSK_FD00; end
        default: ;
      endcase
      word[15:0] = (word[15:0] & ~msk) | pat;
      if (has_operand) begin
        c = word[7:0];
        case ($urandom_range(4))
          0:       c = (c & ~MSK_MEM_FC) | PAT_MEM_RD;
          1:       c = (c & ~MSK_MEM_3C) | PAT_MEM_RA;
          2:       c = (c & ~MSK_MEM_3C) | PAT_MEM_ID;
          3:       c = (c & ~MSK_MEM_38) | PAT_MEM_RM;
          default: ;
        endcase
        word[7:0] = c;
      end
      add_fetch(addr, word);
    end
    total_items = fetch_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (fetch_q.size() != 0 || in_valid_i || decoded_q.size() != 0);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/dspid_pkg.sv
hdl/dspid_mem_dec.sv
hdl/dspid_dec.sv
hdl/dsp_instruction_decoder.sv
tb/testbench.sv
